FILE: hdl/naive_bayes_pixel_trainer_unit_assert.svh
`ifndef NAIVE_BAYES_PIXEL_TRAINER_UNIT_ASSERT_SVH
`define NAIVE_BAYES_PIXEL_TRAINER_UNIT_ASSERT_SVH
// implication check, reset aware
`define NBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication check
`define NBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

FILE: hdl/nbt_pkg.sv
package nbt_pkg;
  localparam logic [1:0] CmdNewImage = 2'd0;
  localparam logic [1:0] CmdPixel    = 2'd1;
  localparam logic [1:0] CmdFeature  = 2'd2;
  localparam logic [1:0] CmdPrior    = 2'd3;
  localparam logic [1:0] RegK        = 2'd0;
  localparam logic [1:0] RegClasses  = 2'd1;
  localparam logic [1:0] RegSide     = 2'd2;
  localparam logic [7:0] CharHash    = 8'h23;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam int         MaxSide     = 32;
  localparam int         MaxClasses  = 16;
  localparam int         CountBits   = 16;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] class_label;
    logic [4:0] row;
    logic [4:0] col;
    logic [7:0] pixel_char;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [16:0] prob_unshaded;
    logic [16:0] prob_shaded;
    logic [16:0] prior;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0] command;
    logic       err;
    logic       shaded;
    logic [3:0] cls;
    logic [4:0] row;
    logic [4:0] col;
  } job_t;
endpackage

FILE: hdl/nbt_front.sv
module nbt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  nbt_pkg::in_item_t item_i,
  input  logic [4:0]        class_count_i,
  input  logic [5:0]        image_side_i,
  input  logic [4:0]        max_classes_i,
  input  logic [6:0]        max_side_i,
  output nbt_pkg::job_t     job_o,
  output logic              new_image_o
);
  logic [3:0] cur_q, cur_d;
  logic [6:0] ncls, side;
  logic       cls_bad, cur_bad, pos_bad;

  always_comb begin
    ncls = ({2'd0, class_count_i} < {2'd0, max_classes_i}) ? {2'd0, class_count_i}
                                                           : {2'd0, max_classes_i};
    side = ({1'b0, image_side_i} < max_side_i) ? {1'b0, image_side_i} : max_side_i;
    cls_bad = {3'd0, item_i.class_label} >= ncls;
    cur_bad = {3'd0, cur_q} >= ncls;
    pos_bad = ({2'd0, item_i.row} >= side) || ({2'd0, item_i.col} >= side);
    job_o.command = item_i.command;
    job_o.shaded  = (item_i.pixel_char == nbt_pkg::CharHash) ||
                    (item_i.pixel_char == nbt_pkg::CharPlus);
    job_o.row = item_i.row;
    job_o.col = item_i.col;
    job_o.cls = item_i.class_label;
    unique case (item_i.command)
      nbt_pkg::CmdNewImage: job_o.err = cls_bad;
      nbt_pkg::CmdPixel: begin
        job_o.err = cur_bad || pos_bad;
        job_o.cls = cur_q;
      end
      nbt_pkg::CmdFeature: job_o.err = cls_bad || pos_bad;
      default: begin
        job_o.err = cls_bad;
        job_o.row = '0;
        job_o.col = '0;
      end
    endcase
    new_image_o = take_i && (item_i.command == nbt_pkg::CmdNewImage) && !cls_bad;
    cur_d = new_image_o ? item_i.class_label : cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end
endmodule

FILE: hdl/nbt_divider.sv
module nbt_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] num_i,
  input  logic [23:0] den_i,
  output logic        done_o,
  output logic [16:0] quot_o
);
  logic [39:0] num_q, num_d;
  logic [24:0] rem_q, rem_d;
  logic [39:0] quo_q, quo_d;
  logic [23:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        fin_q;
  logic [24:0] shifted;

  always_comb begin
    shifted = {rem_q[23:0], num_q[39]};
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
      quo_d = '0;
      cnt_d = 6'd40;
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[38:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[38:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) run_d = 1'b0;
    end
    if (den_q == '0) quot_o = '0;
    else if (quo_q > 40'd65536) quot_o = 17'd65536;
    else quot_o = quo_q[16:0];
  end

  assign done_o = fin_q;

  always_ff @(posedge clk_i) begin
    if (start_i) den_q <= den_i;
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      fin_q <= 1'b0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      fin_q <= run_q && (cnt_q == 6'd1);
    end
  end
endmodule

FILE: hdl/nbt_back.sv
module nbt_back #(
  parameter int AddrBits = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  nbt_pkg::job_t      job_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic [7:0]         k_i,
  input  logic [6:0]         ncls_i,
  input  logic [15:0]        total_i,
  input  logic [15:0]        count_max_i,
  output logic               job_ready_o,
  output logic               clearing_o,
  output logic               valid_o,
  output nbt_pkg::out_item_t result_o
);
  typedef enum logic [6:0] {
    StClear = 7'b0000001, StIdle = 7'b0000010, StRead = 7'b0000100,
    StCalc = 7'b0001000, StDivA = 7'b0010000, StDivB = 7'b0100000,
    StWrite = 7'b1000000
  } st_e;
  localparam int Depth = 1 << AddrBits;

  st_e st_q, st_d;
  logic [15:0] shd_mem [Depth];
  logic [15:0] uns_mem [Depth];
  logic [15:0] shd_rd_q, uns_rd_q;
  logic [AddrBits-1:0] addr_q, clr_q;
  nbt_pkg::job_t job_q;
  logic [15:0] tot_q;
  logic [16:0] pa_q;
  logic [23:0] den;
  logic [39:0] div_num;
  logic        div_start, div_done;
  logic [16:0] div_quot;
  logic        wr_en;
  logic [15:0] wr_shd, wr_uns;
  logic [16:0] sum_su;

  nbt_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(den), .done_o(div_done), .quot_o(div_quot)
  );

  assign job_ready_o = (st_q == StIdle);
  assign clearing_o  = (st_q == StClear);
  assign sum_su = {1'b0, shd_rd_q} + {1'b0, uns_rd_q};

  always_comb begin
    if (job_q.command == nbt_pkg::CmdFeature)
      den = 24'({k_i, 1'b0}) + 24'(sum_su);
    else
      den = 24'({10'd0, ncls_i} * {9'd0, k_i}) + 24'(tot_q);
    st_d = st_q;
    div_start = 1'b0;
    div_num = '0;
    wr_en = 1'b0;
    wr_shd = shd_rd_q;
    wr_uns = uns_rd_q;
    valid_o = 1'b0;
    result_o = '0;
    result_o.status = job_q.err;
    unique case (st_q)
      StClear: if (clr_q == AddrBits'(Depth - 1)) st_d = StIdle;
      StIdle:  if (job_valid_i) st_d = StRead;
      StRead:  st_d = StCalc;
      StCalc: begin
        if (job_q.err || job_q.command == nbt_pkg::CmdNewImage) begin
          valid_o = 1'b1;
          st_d = StIdle;
        end else if (job_q.command == nbt_pkg::CmdPixel) begin
          st_d = StWrite;
        end else begin
          div_start = 1'b1;
          if (job_q.command == nbt_pkg::CmdFeature)
            div_num = {7'd0, 17'({9'd0, k_i} + {1'b0, shd_rd_q}), 16'd0} +
                      {17'd0, den[23:1]};
          else
            div_num = {6'd0, 18'({10'd0, k_i} + {1'b0, sum_su}), 16'd0} +
                      {17'd0, den[23:1]};
          st_d = StDivA;
        end
      end
      StDivA: if (div_done) begin
        if (job_q.command == nbt_pkg::CmdFeature) begin
          div_start = 1'b1;
          div_num = {7'd0, 17'({9'd0, k_i} + {1'b0, uns_rd_q}), 16'd0} +
                    {17'd0, den[23:1]};
          st_d = StDivB;
        end else begin
          valid_o = 1'b1;
          result_o.prior = div_quot;
          st_d = StIdle;
        end
      end
      StDivB: if (div_done) begin
        valid_o = 1'b1;
        result_o.prob_shaded = pa_q;
        result_o.prob_unshaded = div_quot;
        st_d = StIdle;
      end
      StWrite: begin
        wr_en = 1'b1;
        valid_o = 1'b1;
        if (job_q.shaded) begin
          if (shd_rd_q != count_max_i) wr_shd = shd_rd_q + 16'd1;
        end else begin
          if (uns_rd_q != count_max_i) wr_uns = uns_rd_q + 16'd1;
        end
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StClear) begin
      shd_mem[clr_q] <= '0;
      uns_mem[clr_q] <= '0;
    end else if (wr_en) begin
      shd_mem[addr_q] <= wr_shd;
      uns_mem[addr_q] <= wr_uns;
    end
    shd_rd_q <= shd_mem[addr_q];
    uns_rd_q <= uns_mem[addr_q];
    if (st_q == StIdle && job_valid_i) begin
      job_q <= job_i;
      addr_q <= addr_i;
      tot_q <= total_i;
    end
    if (st_q == StDivA && div_done) pa_q <= div_quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      clr_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
    end
  end
endmodule

FILE: hdl/naive_bayes_pixel_trainer_unit.sv
// Each item gives one result pulse (valid_o) that the receiver cannot stall.
// A one-entry queue sits between front and back, so a second item can be
// taken while the first is still in the back. A new-image or rejected item
// gives its result from the calc state, a pixel from the write state, a prior
// query when its one division is done and a feature query when its second is,
// as the shared bit-serial divider works out one quotient at a time.
// After reset all 16384 cells (MaxClasses*MaxSide^2) of the count memories
// are cleared; busy stays high meanwhile.
`include "naive_bayes_pixel_trainer_unit_assert.svh"
module naive_bayes_pixel_trainer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  nbt_pkg::in_item_t   item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  output logic                valid_o,
  output nbt_pkg::out_item_t  result_o
);
  localparam int SideBits = (nbt_pkg::MaxSide > 1) ? $clog2(nbt_pkg::MaxSide) : 1;
  localparam int ClsBits  = (nbt_pkg::MaxClasses > 1) ? $clog2(nbt_pkg::MaxClasses) : 1;
  localparam int AddrBits = ClsBits + 2 * SideBits;
  localparam logic [15:0] CountMax =
    (nbt_pkg::CountBits >= 16) ? 16'hFFFF : 16'((1 << nbt_pkg::CountBits) - 1);

  logic [7:0]  k_q;
  logic [4:0]  ncls_q;
  logic [5:0]  side_q;
  logic [15:0] total_q, q_total_q;
  logic        take, new_img, q_valid_q, back_ready, clearing;
  nbt_pkg::job_t job, q_job_q;
  logic [AddrBits-1:0] addr, q_addr_q;
  logic [6:0] ncls_used;

  assign busy = q_valid_q || clearing;
  assign take = start && !busy;
  assign ncls_used = ({2'd0, ncls_q} < 7'(nbt_pkg::MaxClasses)) ? {2'd0, ncls_q}
                                                                : 7'(nbt_pkg::MaxClasses);
  assign addr = {ClsBits'(job.cls), SideBits'(job.row), SideBits'(job.col)};

  nbt_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .take_i(take), .item_i(item_i),
    .class_count_i(ncls_q), .image_side_i(side_q),
    .max_classes_i(5'(nbt_pkg::MaxClasses > 16 ? 16 : nbt_pkg::MaxClasses)),
    .max_side_i(7'(nbt_pkg::MaxSide)), .job_o(job), .new_image_o(new_img)
  );

  nbt_back #(.AddrBits(AddrBits)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .job_valid_i(q_valid_q), .job_i(q_job_q),
    .addr_i(q_addr_q), .k_i(k_q), .ncls_i(ncls_used), .total_i(q_total_q),
    .count_max_i(CountMax), .job_ready_o(back_ready), .clearing_o(clearing),
    .valid_o(valid_o), .result_o(result_o)
  );

  always_ff @(posedge clk_i) begin
    if (take) begin
      q_job_q <= job;
      q_addr_q <= addr;
      q_total_q <= total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 8'd1;
      ncls_q <= 5'd10;
      side_q <= 6'd28;
      total_q <= '0;
      q_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          nbt_pkg::RegK:       k_q <= cfg_data_i;
          nbt_pkg::RegClasses: ncls_q <= cfg_data_i[4:0];
          nbt_pkg::RegSide:    side_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (new_img && total_q != CountMax) total_q <= total_q + 16'd1;
      if (take) q_valid_q <= 1'b1;
      else if (back_ready) q_valid_q <= 1'b0;
    end
  end

  `NBT_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, busy && start, !take)
  `NBT_ASSERT_IMP(a_no_result_clear, clk_i, rst_ni, clearing, !valid_o)
  `NBT_ASSERT_NXT(a_take_queues, clk_i, rst_ni, take, q_valid_q)
endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Side      = 32;
  localparam int Classes   = 16;
  localparam int Cells     = Classes * Side * Side;
  localparam int CountMax  = 65535;
  localparam int Settle    = 120;
  localparam int CycLimit  = 1200000;

  typedef enum logic [1:0] {TxItem, TxCfg, TxDrain} tx_kind_e;
  typedef struct {
    tx_kind_e          kind;
    nbt_pkg::in_item_t item;
    logic [1:0]        idx;
    logic [7:0]        data;
  } pending_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  nbt_pkg::in_item_t  item_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [7:0]         cfg_data_i = '0;
  logic               valid_o;
  nbt_pkg::out_item_t result_o;

  naive_bayes_pixel_trainer_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pending_t           pending_q[$];
  nbt_pkg::out_item_t expected_q[$];
  int        shaded_cnt[Cells];
  int        unshaded_cnt[Cells];
  int        image_total, cur_class;
  int        k_val = 1, class_cnt = 10, side_val = 28;
  int        errors = 0, n_items = 0, n_results = 0, n_cfg = 0;
  int        cyc = 0, idle_cnt = 0, gap = 0;
  bit        took = 1'b0;
  bit        quiet = 1'b0;

  function automatic logic [16:0] q16(longint num, longint den);
    longint q;
    if (den == 0) return '0;
    q = (num * 65536 + den / 2) / den;
    return (q > 65536) ? 17'd65536 : q[16:0];
  endfunction

  function automatic int sat(int v);
    return (v >= CountMax) ? CountMax : v + 1;
  endfunction

  function automatic nbt_pkg::out_item_t train_step(nbt_pkg::in_item_t it);
    nbt_pkg::out_item_t o;
    int ncls, sd, pos;
    longint s, u, den;
    o = '0;
    ncls = (class_cnt < Classes) ? class_cnt : Classes;
    sd = (side_val < Side) ? side_val : Side;
    case (it.command)
      nbt_pkg::CmdNewImage: begin
        if (it.class_label >= ncls) o.status = 1'b1;
        else begin
          cur_class = it.class_label;
          image_total = sat(image_total);
        end
      end
      nbt_pkg::CmdPixel: begin
        if (cur_class >= ncls || it.row >= sd || it.col >= sd) o.status = 1'b1;
        else begin
          pos = (cur_class * Side + it.row) * Side + it.col;
          if (it.pixel_char == nbt_pkg::CharHash || it.pixel_char == nbt_pkg::CharPlus)
            shaded_cnt[pos] = sat(shaded_cnt[pos]);
          else
            unshaded_cnt[pos] = sat(unshaded_cnt[pos]);
        end
      end
      nbt_pkg::CmdFeature: begin
        if (it.class_label >= ncls || it.row >= sd || it.col >= sd) o.status = 1'b1;
        else begin
          pos = (it.class_label * Side + it.row) * Side + it.col;
          s = shaded_cnt[pos];
          u = unshaded_cnt[pos];
          den = 2 * k_val + s + u;
          o.prob_shaded = q16(k_val + s, den);
          o.prob_unshaded = q16(k_val + u, den);
        end
      end
      default: begin
        if (it.class_label >= ncls) o.status = 1'b1;
        else begin
          pos = it.class_label * Side * Side;
          den = longint'(ncls) * k_val + image_total;
          o.prior = q16(k_val + shaded_cnt[pos] + unshaded_cnt[pos], den);
        end
      end
    endcase
    return o;
  endfunction

  // monitor: check results, then record new transfers and register writes
  always @(posedge clk_i) begin
    nbt_pkg::out_item_t exp_r;
    cyc <= cyc + 1;
    if (cyc > CycLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && valid_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (result_o.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, result_o.status); errors++;
        end
        if (result_o.prob_unshaded !== exp_r.prob_unshaded) begin
          $error("prob_unshaded exp %0d got %0d", exp_r.prob_unshaded,
                 result_o.prob_unshaded); errors++;
        end
        if (result_o.prob_shaded !== exp_r.prob_shaded) begin
          $error("prob_shaded exp %0d got %0d", exp_r.prob_shaded,
                 result_o.prob_shaded); errors++;
        end
        if (result_o.prior !== exp_r.prior) begin
          $error("prior exp %0d got %0d", exp_r.prior, result_o.prior); errors++;
        end
      end
    end
    took = rst_ni && start && !busy;
    if (took) begin
      expected_q = {expected_q, train_step(item_i)};
      n_items++;
    end
    if (rst_ni && cfg_we_i) begin
      n_cfg++;
      case (cfg_idx_i)
        nbt_pkg::RegK:       k_val = cfg_data_i;
        nbt_pkg::RegClasses: class_cnt = cfg_data_i[4:0];
        nbt_pkg::RegSide:    side_val = cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // driver
  always @(negedge clk_i) begin
    logic              n_start, n_we;
    nbt_pkg::in_item_t n_item;
    logic [1:0]        n_idx;
    logic [7:0]        n_data;
    n_start = start;
    n_item = item_i;
    n_we = 1'b0;
    n_idx = cfg_idx_i;
    n_data = cfg_data_i;
    if (expected_q.size() == 0 && !start && !busy) idle_cnt++;
    else idle_cnt = 0;
    if (rst_ni && !(start && !took)) begin
      n_start = 1'b0;
      if (gap > 0) gap--;
      else if (pending_q.size() > 0) begin
        case (pending_q[0].kind)
          TxItem: begin
            n_start = 1'b1;
            n_item = pending_q[0].item;
            void'(pending_q.pop_front());
            gap = pick_gap();
          end
          TxCfg: if (idle_cnt >= Settle) begin
            n_we = 1'b1;
            n_idx = pending_q[0].idx;
            n_data = pending_q[0].data;
            void'(pending_q.pop_front());
          end
          default: if (idle_cnt > 0) void'(pending_q.pop_front());
        endcase
      end
    end
    start <= n_start;
    item_i <= n_item;
    cfg_we_i <= n_we;
    cfg_idx_i <= n_idx;
    cfg_data_i <= n_data;
  end

  task automatic add_item(logic [1:0] cmd, int cls, int r, int c, int ch);
    pending_t p;
    p.kind = TxItem;
    p.item.command = cmd;
    p.item.class_label = cls[3:0];
    p.item.row = r[4:0];
    p.item.col = c[4:0];
    p.item.pixel_char = ch[7:0];
    p.idx = '0;
    p.data = '0;
    pending_q = {pending_q, p};
  endtask

  task automatic add_cfg(int k, int cls, int sd);
    pending_t p;
    p.kind = TxCfg;
    p.item = '0;
    p.idx = nbt_pkg::RegK;       p.data = k[7:0];   pending_q = {pending_q, p};
    p.idx = nbt_pkg::RegClasses; p.data = cls[7:0]; pending_q = {pending_q, p};
    p.idx = nbt_pkg::RegSide;    p.data = sd[7:0];  pending_q = {pending_q, p};
  endtask

  task automatic add_drain();
    pending_t p;
    p.kind = TxDrain;
    p.item = '0;
    p.idx = '0;
    p.data = '0;
    pending_q = {pending_q, p};
  endtask

  function automatic int rand_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return nbt_pkg::CharHash;
    if (r < 5) return nbt_pkg::CharPlus;
    return $urandom_range(0, 255);
  endfunction

  task automatic add_random(int n, int ncls, int sd);
    int cnt, m, cls;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 7 && ncls > 0 && sd > 0) begin
        cls = $urandom_range(0, ncls - 1);
        add_item(nbt_pkg::CmdNewImage, cls, 0, 0, $urandom_range(0, 255));
        m = $urandom_range(1, 30);
        repeat (m) begin
          if ($urandom_range(0, 7) == 0) add_item(nbt_pkg::CmdPixel, 0, 0, 0, rand_char());
          else add_item(nbt_pkg::CmdPixel, 0, $urandom_range(0, sd - 1),
                        $urandom_range(0, sd - 1), rand_char());
        end
        if ($urandom_range(0, 1))
          add_item(nbt_pkg::CmdFeature, cls, $urandom_range(0, sd - 1),
                   $urandom_range(0, sd - 1), $urandom_range(0, 255));
        else add_item(nbt_pkg::CmdPrior, $urandom_range(0, ncls - 1),
                      $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 255));
        cnt += m + 2;
      end else begin
        add_item(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 255));
        cnt++;
      end
    end
  endtask

  initial begin
    int ks[6];
    int cs[6];
    int sds[6];
    int ncls, sd;
    ks  = '{1, 255, 0, 1, 7, 3};
    cs  = '{10, 16, 31, 1, 0, 5};
    sds = '{28, 32, 63, 1, 0, 4};
    // directed, reset configuration
    add_item(nbt_pkg::CmdNewImage, 0, 0, 0, 0);
    add_item(nbt_pkg::CmdPixel, 0, 0, 0, nbt_pkg::CharHash);
    add_item(nbt_pkg::CmdPixel, 0, 0, 0, nbt_pkg::CharPlus);
    add_item(nbt_pkg::CmdPixel, 0, 0, 0, 8'h61);
    add_item(nbt_pkg::CmdPixel, 0, 27, 27, 0);
    add_item(nbt_pkg::CmdPixel, 0, 27, 27, 255);
    add_item(nbt_pkg::CmdPixel, 0, 28, 0, nbt_pkg::CharHash);
    add_item(nbt_pkg::CmdPixel, 0, 0, 31, nbt_pkg::CharHash);
    add_item(nbt_pkg::CmdFeature, 0, 0, 0, 0);
    add_item(nbt_pkg::CmdFeature, 0, 27, 27, 0);
    add_item(nbt_pkg::CmdFeature, 0, 31, 0, 0);
    add_item(nbt_pkg::CmdFeature, 9, 5, 5, 0);
    add_item(nbt_pkg::CmdFeature, 15, 0, 0, 0);
    add_item(nbt_pkg::CmdPrior, 0, 0, 0, 0);
    add_item(nbt_pkg::CmdPrior, 15, 0, 0, 0);
    add_item(nbt_pkg::CmdNewImage, 15, 0, 0, 0);
    add_item(nbt_pkg::CmdNewImage, 9, 0, 0, 0);
    add_item(nbt_pkg::CmdPixel, 0, 31, 31, nbt_pkg::CharPlus);
    add_item(nbt_pkg::CmdPrior, 9, 0, 0, 0);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        add_drain();
        add_cfg(ks[ph], cs[ph], sds[ph]);
      end
      ncls = (cs[ph] < Classes) ? cs[ph] : Classes;
      sd = (sds[ph] < Side) ? sds[ph] : Side;
      if (ph == 2) add_item(nbt_pkg::CmdFeature, 12, 30, 30, 0);
      if (ph == 3) begin
        add_item(nbt_pkg::CmdNewImage, 0, 0, 0, 0);
        repeat (6) add_item(nbt_pkg::CmdPixel, 0, 0, 0, nbt_pkg::CharHash);
        add_item(nbt_pkg::CmdPrior, 0, 0, 0, 0);
      end
      add_random(150, ncls, sd);
      add_drain();
      add_random(150, ncls, sd);
    end
    add_drain();
  end

  initial begin
    for (int i = 0; i < Cells; i++) begin
      shaded_cnt[i] = 0;
      unshaded_cnt[i] = 0;
    end
    image_total = 0;
    cur_class = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (!busy);
    repeat (200) @(posedge clk_i);
    quiet = 1'b1;
    repeat (3000) @(posedge clk_i);
    quiet = 1'b0;
    wait (pending_q.size() == 0 && !start && expected_q.size() == 0);
    repeat (Settle) @(posedge clk_i);
    $display("Ran %0d items over six register settings, %0d results, %0d writes",
             n_items, n_results, n_cfg);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/nbt_pkg.sv
hdl/nbt_front.sv
hdl/nbt_divider.sv
hdl/nbt_back.sv
hdl/naive_bayes_pixel_trainer_unit.sv
sim/tb.sv
